@@ rtl/tlks_pkg.sv @@
// Package for the three-register keystream decryptor: constants, types and the register step.
package tlks_pkg;

  localparam int unsigned RegW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEED_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEED_C = 2'd2;

  // Feedback masks and fill patterns of the three shift registers
  localparam logic [RegW-1:0] MASK_A = 32'h8000_0062;
  localparam logic [RegW-1:0] MASK_B = 32'h4000_0020;
  localparam logic [RegW-1:0] MASK_C = 32'h1000_0002;
  localparam logic [RegW-1:0] FILL_A = 32'h8000_0000;
  localparam logic [RegW-1:0] FILL_B = 32'hC000_0000;
  localparam logic [RegW-1:0] FILL_C = 32'hF000_0000;

  // Seed values after reset
  localparam logic [RegW-1:0] SEED_A_RST = 32'h3031_3233;
  localparam logic [RegW-1:0] SEED_B_RST = 32'h3435_3637;
  localparam logic [RegW-1:0] SEED_C_RST = 32'h3839_3031;

  typedef logic [RegW-1:0] lfsr_t;

  // One Galois step: odd value folds in the mask and sets the fill bits,
  // even value shifts and clears them
  function automatic lfsr_t lfsr_step(lfsr_t r, lfsr_t mask, lfsr_t fill);
    lfsr_t res;
    if (r[0]) begin
      res = ((r ^ mask) >> 1) | fill;
    end else begin
      res = (r >> 1) & ~fill;
    end
    return res;
  endfunction

endpackage

@@ rtl/three_lfsr_keystream_decrypt.sv @@
// Top level: streaming byte decryptor with a three-register alternating-step keystream.
// An accepted byte moves from the input register into the result register. Throughput: one
// byte per cycle while the result side is not stalled; the eight register steps are
// combinational between the input register and the result register, and the shift
// registers advance once per byte.
// Reset (rst_n low, synchronous): seeds return to their defaults, the shift registers load
// the default seeds, both stages empty. No clearing pass; first transfer may follow at once.
module three_lfsr_keystream_decrypt (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tlks_pkg::ByteW-1:0]    in_tdata,   // [7:0] cipher_byte
  input  logic                          in_tuser,   // [0] first_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tlks_pkg::ByteW-1:0]    out_tdata,  // [7:0] plain_byte
  // configuration write port
  input  logic                          cfg_we,
  input  logic [tlks_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tlks_pkg::RegW-1:0]     cfg_wdata
);
  import tlks_pkg::*;

  lfsr_t seed_a_r, seed_b_r, seed_c_r;
  lfsr_t reg_a_r, reg_b_r, reg_c_r;
  lfsr_t reg_a_nxt, reg_b_nxt, reg_c_nxt;

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_cipher_r;
  logic             s1_first_r;

  logic             out_valid_r;
  logic [ByteW-1:0] out_byte_r;

  logic             adv;
  logic             s1_fire;
  logic [ByteW-1:0] key;

  // Result register frees when empty or taken; input register moves on then
  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  // Seed registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r <= SEED_A_RST;
      seed_b_r <= SEED_B_RST;
      seed_c_r <= SEED_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_A: seed_a_r <= cfg_wdata;
        CFG_SEED_B: seed_b_r <= cfg_wdata;
        CFG_SEED_C: seed_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Eight alternating steps; key collected most significant bit first
  always_comb begin
    logic ob, oc, sel;
    if (s1_first_r) begin
      reg_a_nxt = seed_a_r;
      reg_b_nxt = seed_b_r;
      reg_c_nxt = seed_c_r;
    end else begin
      reg_a_nxt = reg_a_r;
      reg_b_nxt = reg_b_r;
      reg_c_nxt = reg_c_r;
    end
    ob  = reg_b_nxt[0];
    oc  = reg_c_nxt[0];
    key = '0;
    for (int i = 0; i < ByteW; i++) begin
      sel       = reg_a_nxt[0];
      reg_a_nxt = lfsr_step(reg_a_nxt, MASK_A, FILL_A);
      if (sel) begin
        ob        = reg_b_nxt[0];
        reg_b_nxt = lfsr_step(reg_b_nxt, MASK_B, FILL_B);
      end else begin
        oc        = reg_c_nxt[0];
        reg_c_nxt = lfsr_step(reg_c_nxt, MASK_C, FILL_C);
      end
      key[ByteW-1-i] = ob ^ oc;
    end
  end

  // Shift registers advance once per byte moved into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_a_r <= SEED_A_RST;
      reg_b_r <= SEED_B_RST;
      reg_c_r <= SEED_C_RST;
    end else if (s1_fire) begin
      reg_a_r <= reg_a_nxt;
      reg_b_r <= reg_b_nxt;
      reg_c_r <= reg_c_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cipher_r <= in_tdata;
      s1_first_r  <= in_tuser;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r <= s1_cipher_r ^ key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

endmodule

@@ rtl/tlks_checker.sv @@
// Port-level checker for the keystream decryptor, bound to the top level.
module tlks_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tlks_pkg::ByteW-1:0]  out_tdata
);

  // Result stays and holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Result register empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A free result side never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with result side ready");

  // Accepted byte passes the input register and reaches the result register when the result side is ready
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted byte did not show as a result");

endmodule

bind three_lfsr_keystream_decrypt tlks_checker u_tlks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
